@@ sv/variable_length_code_bit_decoder_core_macros.svh @@
// assertion macros for the vlc bit decoder
`ifndef VARIABLE_LENGTH_CODE_BIT_DECODER_CORE_MACROS_SVH
`define VARIABLE_LENGTH_CODE_BIT_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define VLCBD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define VLCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/vlcbd_pkg.sv @@
package vlcbd_pkg;

	localparam int DATA_W  = 16;
	localparam int ALPHA_W = 16;

	// command codes
	localparam logic [1:0] CMD_START_LIT   = 2'd0;
	localparam logic [1:0] CMD_START_LEAF  = 2'd1;
	localparam logic [1:0] CMD_START_TRUNC = 2'd2;
	localparam logic [1:0] CMD_DATA        = 2'd3;

	// code kinds
	localparam logic [1:0] KIND_LIT   = 2'd0;
	localparam logic [1:0] KIND_LEAF  = 2'd1;
	localparam logic [1:0] KIND_TRUNC = 2'd2;

	// result status
	localparam logic ST_DONE  = 1'b0;
	localparam logic ST_STRAY = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_PREFIX = 2'd1,
		PH_SUFFIX = 2'd2,
		PH_EXTRA  = 2'd3
	} vlcbd_phase_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic               bit_value;
		logic [ALPHA_W-1:0] alphabet_size;
	} vlcbd_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] decoded_value;
		logic [1:0]        code_kind;
		logic              status;
	} vlcbd_rsp_t;

	// control part of the decoder state
	typedef struct packed {
		vlcbd_phase_t phase;
		logic [1:0]   kind;
	} vlcbd_ctl_t;

	// highest set bit of v, one when v is zero
	function automatic logic [ALPHA_W-1:0] top_bit(input logic [ALPHA_W-1:0] v);
		logic [ALPHA_W-1:0] s;
		s = v | (v >> 1);
		s = s | (s >> 2);
		s = s | (s >> 4);
		s = s | (s >> 8);
		if (v == '0) begin
			top_bit = {{(ALPHA_W-1){1'b0}}, 1'b1};
		end else begin
			top_bit = s ^ (s >> 1);
		end
	endfunction

endpackage

@@ sv/variable_length_code_bit_decoder_core.sv @@
// channel | valid     | stall     | payload           | moves
// --------+-----------+-----------+-------------------+--------------------------------
// request | req_valid | req_stall | req (vlcbd_req_t) | start command or one coded bit
// result  | rsp_valid | rsp_stall | rsp (vlcbd_rsp_t) | finished code or stray status
//
// one request transfer per cycle while req_stall is low
// path is input register, one decode step of add/shift/compare, result register
// arst_n clears the decoder to idle with both stages empty
// a stalled result blocks the input register only, and req_stall rises only
// while the input register holds an item and the result register is full
`include "variable_length_code_bit_decoder_core_macros.svh"

module variable_length_code_bit_decoder_core
	import vlcbd_pkg::*;
#(
	parameter int VALUE_WIDTH        = 16,
	parameter int LITERAL_PREFIX_CAP = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  vlcbd_req_t req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output vlcbd_rsp_t rsp
);

	// accumulator holds a leaf value or a 16 bit literal/truncated value
	localparam int ACC_W = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

	// input register
	logic       item_valid_s1;
	vlcbd_req_t item_s1;

	// result register
	logic       rsp_valid_s2;
	vlcbd_rsp_t rsp_s2;

	// decoder state
	vlcbd_ctl_t         ctl_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   wt_q;
	logic [ALPHA_W-1:0] mask_q;
	logic [ALPHA_W-1:0] alpha_q;

	// next state from the decode step
	vlcbd_ctl_t         ctl_nxt;
	logic [ACC_W-1:0]   acc_nxt;
	logic [ACC_W-1:0]   wt_nxt;
	logic [ALPHA_W-1:0] mask_nxt;
	logic [ALPHA_W-1:0] alpha_nxt;
	logic               res_valid;
	vlcbd_rsp_t         res;

	logic out_blocked;
	logic step_go;
	logic req_xfer;
	logic rsp_xfer;

	// the held item can only be decoded when its result has somewhere to go
	assign out_blocked = rsp_valid_s2 && rsp_stall;
	assign step_go     = item_valid_s1 && !out_blocked;
	assign req_stall   = item_valid_s1 && out_blocked;
	assign req_xfer    = req_valid && !req_stall;
	assign rsp_xfer    = rsp_valid_s2 && !rsp_stall;

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	vlcbd_step #(
		.VALUE_WIDTH        (VALUE_WIDTH),
		.LITERAL_PREFIX_CAP (LITERAL_PREFIX_CAP),
		.ACC_W              (ACC_W)
	) u_step (
		.item      (item_s1),
		.ctl       (ctl_q),
		.acc       (acc_q),
		.wt        (wt_q),
		.mask      (mask_q),
		.alpha     (alpha_q),
		.ctl_nxt   (ctl_nxt),
		.acc_nxt   (acc_nxt),
		.wt_nxt    (wt_nxt),
		.mask_nxt  (mask_nxt),
		.alpha_nxt (alpha_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// input register: reload on every transfer, empty once decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (req_xfer) begin
			item_valid_s1 <= 1'b1;
		end else if (step_go) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			item_s1 <= req;
		end
	end

	// result register: a new result may replace one leaving this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (step_go && res_valid) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp_xfer) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && res_valid) begin
			rsp_s2 <= res;
		end
	end

	// decoder state, advanced once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '{phase: PH_IDLE, kind: KIND_LIT};
			acc_q   <= '0;
			wt_q    <= ACC_W'(1);
			mask_q  <= '0;
			alpha_q <= '0;
		end else if (step_go) begin
			ctl_q   <= ctl_nxt;
			acc_q   <= acc_nxt;
			wt_q    <= wt_nxt;
			mask_q  <= mask_nxt;
			alpha_q <= alpha_nxt;
		end
	end

	// weight is a single bit while prefix or suffix bits are still due
	`VLCBD_ASSERT_IMPL(a_weight_onehot, ctl_q.phase == PH_PREFIX || ctl_q.phase == PH_SUFFIX, $onehot(wt_q), "bit weight not one-hot during a run")
	// waiting on the extra bit only for a short truncated code
	`VLCBD_ASSERT_IMPL(a_extra_short, ctl_q.phase == PH_EXTRA, ctl_q.kind == KIND_TRUNC && acc_q < ACC_W'(mask_q), "extra bit pending without a short code")
	// a finished code returns the decoder to idle
	`VLCBD_ASSERT_NEXT(a_done_idle, step_go && res_valid && res.status == ST_DONE, ctl_q.phase == PH_IDLE, "decoder not idle after a finished code")
	// a stray result never touches the decoder state
	`VLCBD_ASSERT_NEXT(a_stray_keeps, step_go && res_valid && res.status == ST_STRAY, $stable(ctl_q) && $stable(acc_q), "stray bit changed decoder state")

endmodule

@@ sv/vlcbd_step.sv @@
module vlcbd_step
	import vlcbd_pkg::*;
#(
	parameter int VALUE_WIDTH        = 16,
	parameter int LITERAL_PREFIX_CAP = 5,
	parameter int ACC_W              = 16
) (
	input  vlcbd_req_t         item,
	input  vlcbd_ctl_t         ctl,
	input  logic [ACC_W-1:0]   acc,
	input  logic [ACC_W-1:0]   wt,
	input  logic [ALPHA_W-1:0] mask,
	input  logic [ALPHA_W-1:0] alpha,
	output vlcbd_ctl_t         ctl_nxt,
	output logic [ACC_W-1:0]   acc_nxt,
	output logic [ACC_W-1:0]   wt_nxt,
	output logic [ALPHA_W-1:0] mask_nxt,
	output logic [ALPHA_W-1:0] alpha_nxt,
	output logic               res_valid,
	output vlcbd_rsp_t         res
);

	logic [ALPHA_W-1:0] m;
	logic [ACC_W-1:0]   acc_sum;
	logic [ACC_W-1:0]   acc_bit;
	logic               cap_hit;
	logic [DATA_W-1:0]  trunc_low;
	logic [DATA_W-1:0]  extra_hi;
	logic [ACC_W-1:0]   short_lim;

	assign m         = top_bit(item.alphabet_size);
	assign acc_sum   = acc + wt;
	assign acc_bit   = item.bit_value ? acc_sum : acc;
	assign cap_hit   = (ctl.kind == KIND_LIT) ? wt[LITERAL_PREFIX_CAP-1] : wt[VALUE_WIDTH-1];
	assign trunc_low = mask - acc_bit[DATA_W-1:0] - DATA_W'(1);
	assign extra_hi  = acc[DATA_W-1:0] + mask;
	assign short_lim = ACC_W'(alpha & ~mask);

	always_comb begin
		ctl_nxt   = ctl;
		acc_nxt   = acc;
		wt_nxt    = wt;
		mask_nxt  = mask;
		alpha_nxt = alpha;
		res_valid = 1'b0;
		res       = '0;
		res.code_kind = ctl.kind;
		res.status    = ST_DONE;

		case (item.cmd)
			CMD_START_LIT, CMD_START_LEAF: begin
				ctl_nxt.phase = PH_PREFIX;
				ctl_nxt.kind  = (item.cmd == CMD_START_LIT) ? KIND_LIT : KIND_LEAF;
				wt_nxt        = ACC_W'(1);
				acc_nxt       = '0;
			end
			CMD_START_TRUNC: begin
				ctl_nxt.kind  = KIND_TRUNC;
				alpha_nxt     = item.alphabet_size;
				mask_nxt      = m;
				acc_nxt       = '0;
				wt_nxt        = ACC_W'(m >> 1);
				// size zero or one: nothing to read, value zero
				if (m[ALPHA_W-1:1] == '0) begin
					ctl_nxt.phase = PH_IDLE;
					res_valid     = 1'b1;
					res.code_kind = KIND_TRUNC;
				end else begin
					ctl_nxt.phase = PH_SUFFIX;
				end
			end
			default: begin
				case (ctl.phase)
					PH_PREFIX: begin
						acc_nxt = acc_bit;
						if (item.bit_value && !cap_hit) begin
							wt_nxt = wt << 1;
						end else if (item.bit_value && ctl.kind != KIND_LIT) begin
							// leaf run at its cap: all ones, no suffix
							ctl_nxt.phase     = PH_IDLE;
							res_valid         = 1'b1;
							res.decoded_value = acc_bit[DATA_W-1:0];
						end else if (item.bit_value) begin
							// literal run at its cap: suffix at the same weight
							ctl_nxt.phase = PH_SUFFIX;
						end else if (wt[0]) begin
							// empty run
							ctl_nxt.phase     = PH_IDLE;
							res_valid         = 1'b1;
							res.decoded_value = acc[DATA_W-1:0];
						end else begin
							wt_nxt        = wt >> 1;
							ctl_nxt.phase = PH_SUFFIX;
						end
					end
					PH_SUFFIX: begin
						acc_nxt = acc_bit;
						wt_nxt  = wt >> 1;
						if (wt[0]) begin
							if (ctl.kind == KIND_TRUNC && acc_bit < short_lim) begin
								ctl_nxt.phase = PH_EXTRA;
							end else begin
								ctl_nxt.phase     = PH_IDLE;
								res_valid         = 1'b1;
								res.decoded_value = (ctl.kind == KIND_TRUNC) ? trunc_low
									: acc_bit[DATA_W-1:0];
							end
						end
					end
					PH_EXTRA: begin
						ctl_nxt.phase     = PH_IDLE;
						res_valid         = 1'b1;
						res.decoded_value = item.bit_value ? extra_hi
							: (mask - acc[DATA_W-1:0] - DATA_W'(1));
					end
					default: begin
						// stray bit, state untouched
						res_valid     = 1'b1;
						res.code_kind = KIND_LIT;
						res.status    = ST_STRAY;
					end
				endcase
			end
		endcase
	end

endmodule
